// ===== rtl/ipdelin_pkg.sv =====
// Shared types and constants for the IP packet delineator.
// Used by the front, queue, back and top-level modules; depends on nothing.
package ipdelin_pkg;

   localparam logic [15:0] MtuReset        = 16'd1500;
   localparam logic [47:0] DestMacReset    = 48'h0;
   localparam logic [47:0] SrcMacReset     = 48'hB69124A81472;
   localparam logic [16:0] Ipv6FixedHdr    = 17'd40;
   localparam logic [15:0] Ipv6HdrKept     = 16'd6;
   localparam logic [15:0] Ipv4HdrKept     = 16'd4;
   localparam logic [3:0]  VerIpv4         = 4'h4;
   localparam logic [3:0]  VerIpv6         = 4'h6;
   localparam logic [15:0] EthTypeIpv4     = 16'h0800;
   localparam logic [15:0] EthTypeIpv6     = 16'h86DD;
   localparam int          EthHdrBytes     = 14;
   localparam int          QueueDepthDefault = 4;

   // Register indexes on the configuration port.
   localparam logic [1:0] CsrMtu     = 2'd0;
   localparam logic [1:0] CsrDestMac = 2'd1;
   localparam logic [1:0] CsrSrcMac  = 2'd2;

   typedef enum logic [1:0] {
      ST_FRAME       = 2'd0,
      ST_BAD_VERSION = 2'd1,
      ST_BAD_LENGTH  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_ERR  = 2'd0,
      CMD_HDR  = 2'd1,
      CMD_BODY = 2'd2
   } cmd_kind_type;

   // One command per input byte that causes results. For a body byte the
   // byte travels in bytes[0].
   typedef struct packed {
      cmd_kind_type     kind;
      status_type       status;
      logic             is_ipv6;
      logic             last;
      logic [5:0][7:0]  bytes;
   } cmd_type;

endpackage

// ===== rtl/ipdelin_front.sv =====
// Front end of the IP packet delineator: hunts, collects headers, checks
// lengths and makes a command of each byte that yields results. Depends on ipdelin_pkg.
module ipdelin_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_accept,
   input  logic [7:0]           rx_byte,
   input  logic                 chunk_end,
   input  logic [15:0]          mtu,
   output logic                 push_valid,
   output ipdelin_pkg::cmd_type push_cmd
);
   import ipdelin_pkg::*;

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_BODY    = 2'd2,
      PH_DISCARD = 2'd3
   } phase_type;

   phase_type       phase_ff, phase_in;
   logic [5:0][7:0] hdr_ff, hdr_in, hdr_cur;
   logic [2:0]      count_ff, count_in;
   logic            is6_ff, is6_in;
   logic [15:0]     left_ff, left_in;

   logic [2:0]      last_idx;
   logic [2:0]      idx;
   logic [15:0]     ipv4_total;
   logic [15:0]     ipv6_pl;
   logic [16:0]     ipv6_total;
   logic            len_ok;
   logic [15:0]     left_new;
   logic [15:0]     left_dec;
   logic [3:0]      ver;

   always_comb begin
      ver        = rx_byte[7:4];
      last_idx   = is6_ff ? 3'd5 : 3'd3;
      idx        = (count_ff > last_idx) ? last_idx : count_ff;
      hdr_cur    = hdr_ff;
      hdr_cur[idx] = rx_byte;
      ipv4_total = {hdr_ff[2], rx_byte};
      ipv6_pl    = {hdr_ff[4], rx_byte};
      ipv6_total = {1'b0, ipv6_pl} + Ipv6FixedHdr;
      // The IPv6 bound is taken on 40 + payload so a tiny MTU rejects all.
      if (is6_ff) begin
         len_ok   = (ipv6_pl >= Ipv6HdrKept) && (ipv6_total <= {1'b0, mtu});
         left_new = 16'(ipv6_total - {1'b0, Ipv6HdrKept});
      end else begin
         len_ok   = (ipv4_total >= Ipv4HdrKept) && (ipv4_total <= mtu);
         left_new = ipv4_total - Ipv4HdrKept;
      end
      left_dec = left_ff - 16'd1;

      phase_in = phase_ff;
      hdr_in   = hdr_ff;
      count_in = count_ff;
      is6_in   = is6_ff;
      left_in  = left_ff;

      push_valid       = 1'b0;
      push_cmd.kind    = CMD_ERR;
      push_cmd.status  = ST_FRAME;
      push_cmd.is_ipv6 = is6_ff;
      push_cmd.last    = 1'b0;
      push_cmd.bytes   = hdr_cur;

      if (in_accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (ver != VerIpv4 && ver != VerIpv6) begin
                  push_valid      = 1'b1;
                  push_cmd.kind   = CMD_ERR;
                  push_cmd.status = ST_BAD_VERSION;
                  phase_in = chunk_end ? PH_HUNT : PH_DISCARD;
                  count_in = 3'd0;
                  left_in  = 16'd0;
               end else begin
                  is6_in    = (ver == VerIpv6);
                  hdr_in[0] = rx_byte;
                  count_in  = 3'd1;
                  phase_in  = PH_HEADER;
               end
            end
            PH_HEADER: begin
               hdr_in = hdr_cur;
               if (idx == last_idx) begin
                  count_in   = 3'd0;
                  push_valid = 1'b1;
                  if (len_ok) begin
                     push_cmd.kind = CMD_HDR;
                     push_cmd.last = (left_new == 16'd0);
                     left_in  = left_new;
                     phase_in = (left_new != 16'd0) ? PH_BODY : PH_HUNT;
                  end else begin
                     push_cmd.kind   = CMD_ERR;
                     push_cmd.status = ST_BAD_LENGTH;
                     left_in  = 16'd0;
                     phase_in = chunk_end ? PH_HUNT : PH_DISCARD;
                  end
               end else begin
                  count_in = idx + 3'd1;
               end
            end
            PH_BODY: begin
               push_valid        = 1'b1;
               push_cmd.kind     = CMD_BODY;
               push_cmd.last     = (left_dec == 16'd0);
               push_cmd.bytes[0] = rx_byte;
               left_in = left_dec;
               if (left_dec == 16'd0) begin
                  phase_in = PH_HUNT;
               end
            end
            PH_DISCARD: begin
               if (chunk_end) begin
                  phase_in = PH_HUNT;
               end
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= 3'd0;
         is6_ff   <= 1'b0;
         left_ff  <= 16'd0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         is6_ff   <= is6_in;
         left_ff  <= left_in;
      end
      hdr_ff <= hdr_in;
   end

   a_body_has_bytes: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> left_ff != 16'd0)
      else $error("body phase with no bytes left");

   a_header_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HEADER |-> count_ff != 3'd0 && count_ff <= (is6_ff ? 3'd5 : 3'd3))
      else $error("header count out of range");

   a_push_on_accept: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> in_accept)
      else $error("command pushed without an accepted byte");

endmodule

// ===== rtl/ipdelin_queue.sv =====
// Short command queue between front and back of the IP packet delineator.
// Register-based circular buffer; depends on ipdelin_pkg for the entry type.
module ipdelin_queue #(
   parameter int Depth = ipdelin_pkg::QueueDepthDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ipdelin_pkg::cmd_type push_cmd,
   input  logic                 pop,
   output ipdelin_pkg::cmd_type head_cmd,
   output logic                 empty,
   output logic                 full
);
   import ipdelin_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   cmd_type          entry_ff [Depth];
   logic [PtrW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] ptr);
      next_ptr = (ptr == PtrW'(Depth - 1)) ? '0 : ptr + PtrW'(1);
   endfunction

   always_comb begin
      empty    = (cnt_ff == '0);
      full     = (cnt_ff == CntW'(Depth));
      head_cmd = entry_ff[rd_ff];
      wr_in    = push ? next_ptr(wr_ff) : wr_ff;
      rd_in    = pop ? next_ptr(rd_ff) : rd_ff;
      cnt_in   = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + CntW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue underflow");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + CntW'(1))
      else $error("queue count did not advance on push");

endmodule

// ===== rtl/ipdelin_back.sv =====
// Back end of the IP packet delineator: expands queued commands into result
// requests behind an output register. Depends on ipdelin_pkg.
module ipdelin_back (
   input  logic                 clock,
   input  logic                 reset,
   input  ipdelin_pkg::cmd_type head_cmd,
   input  logic                 empty,
   output logic                 pop,
   input  logic [47:0]          dest_mac,
   input  logic [47:0]          src_mac,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           frame_byte,
   output logic                 frame_first,
   output logic                 frame_last,
   output ipdelin_pkg::status_type status,
   output logic                 run_last
);
   import ipdelin_pkg::*;

   localparam int SeqLen = EthHdrBytes + 6;

   logic [4:0]  k_ff, k_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        first_ff, first_in;
   logic        flast_ff, flast_in;
   status_type  status_ff, status_in;
   logic        rlast_ff, rlast_in;

   logic        out_free;
   logic        emit;
   logic [4:0]  k_end;
   logic        hdr_done;
   logic [15:0] eth_type;
   logic [7:0]  hdr_seq [SeqLen];

   always_comb begin
      eth_type = head_cmd.is_ipv6 ? EthTypeIpv6 : EthTypeIpv4;
      for (int i = 0; i < 6; i++) begin
         hdr_seq[i]     = dest_mac[8*(5-i) +: 8];
         hdr_seq[i + 6] = src_mac[8*(5-i) +: 8];
         hdr_seq[i + EthHdrBytes] = head_cmd.bytes[i];
      end
      hdr_seq[12] = eth_type[15:8];
      hdr_seq[13] = eth_type[7:0];

      out_free = !valid_ff || rsp_tready;
      emit     = out_free && !empty;
      k_end    = head_cmd.is_ipv6 ? 5'(SeqLen - 1) : 5'(SeqLen - 3);
      hdr_done = (k_ff == k_end);
      pop      = 1'b0;
      k_in     = k_ff;

      valid_in  = out_free ? !empty : valid_ff;
      byte_in   = byte_ff;
      first_in  = first_ff;
      flast_in  = flast_ff;
      status_in = status_ff;
      rlast_in  = rlast_ff;

      if (emit) begin
         unique case (head_cmd.kind)
            CMD_HDR: begin
               byte_in   = hdr_seq[k_ff];
               first_in  = (k_ff == 5'd0);
               flast_in  = hdr_done && head_cmd.last;
               status_in = ST_FRAME;
               rlast_in  = hdr_done;
               pop       = hdr_done;
               k_in      = hdr_done ? 5'd0 : k_ff + 5'd1;
            end
            CMD_BODY: begin
               byte_in   = head_cmd.bytes[0];
               first_in  = 1'b0;
               flast_in  = head_cmd.last;
               status_in = ST_FRAME;
               rlast_in  = 1'b1;
               pop       = 1'b1;
            end
            default: begin
               byte_in   = 8'd0;
               first_in  = 1'b0;
               flast_in  = 1'b0;
               status_in = head_cmd.status;
               rlast_in  = 1'b1;
               pop       = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= 5'd0;
         valid_ff <= 1'b0;
      end else begin
         k_ff     <= k_in;
         valid_ff <= valid_in;
      end
      byte_ff   <= byte_in;
      first_ff  <= first_in;
      flast_ff  <= flast_in;
      status_ff <= status_in;
      rlast_ff  <= rlast_in;
   end

   assign rsp_tvalid  = valid_ff;
   assign frame_byte  = byte_ff;
   assign frame_first = first_ff;
   assign frame_last  = flast_ff;
   assign status      = status_ff;
   assign run_last    = rlast_ff;

   a_seq_has_cmd: assert property (@(posedge clock) disable iff (reset)
      k_ff != 5'd0 |-> !empty)
      else $error("header sequence running with an empty queue");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      valid_ff && status_ff != ST_FRAME |-> rlast_ff && !first_ff && !flast_ff)
      else $error("malformed error result");

   a_first_is_frame: assert property (@(posedge clock) disable iff (reset)
      valid_ff && first_ff |-> status_ff == ST_FRAME && !rlast_ff)
      else $error("frame start on a non-frame result");

endmodule

// ===== rtl/ip_stream_packet_delineator_core.sv =====
// Top level of the IP packet delineator: configuration registers and the
// front / queue / back pipeline. Depends on ipdelin_pkg and the ipdelin_* modules.
//
//  channel  | direction | payload
//  req_*    | in        | tdata[7:0] rx_byte, tlast chunk_end
//  rsp_*    | out       | tdata[7:0] frame_byte, tdata[8] run_last,
//           |           | tuser[0] frame_first, tuser[2:1] status, tlast frame_last
//  csr_*    | in        | csr_index register, csr_data value (always ready)
//
// One request per cycle is taken while the command queue has room. A body byte
// yields one result; an accepted header yields 18 (IPv4) or 20 (IPv6) results,
// one per cycle from the back end while rsp_tready allows, so the front stalls
// once the queue fills. Results leave through a single output register. Reset is
// synchronous and restores the configuration defaults and the hunt state.
module ip_stream_packet_delineator_core #(
   parameter int QueueDepth = ipdelin_pkg::QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] frame_byte, [8] run_last, rest zero
   output logic [2:0]  rsp_tuser,   // [0] frame_first, [2:1] status
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_data
);
   import ipdelin_pkg::*;

   logic [15:0] mtu_ff;
   logic [47:0] dest_mac_ff;
   logic [47:0] src_mac_ff;
   logic        csr_write;

   logic        in_accept;
   logic        push_valid;
   cmd_type     push_cmd;
   cmd_type     head_cmd;
   logic        q_empty;
   logic        q_full;
   logic        pop;

   logic [7:0]  frame_byte;
   logic        frame_first;
   logic        frame_last;
   status_type  status;
   logic        run_last;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mtu_ff      <= MtuReset;
         dest_mac_ff <= DestMacReset;
         src_mac_ff  <= SrcMacReset;
      end else if (csr_write) begin
         unique case (csr_index)
            CsrMtu:     mtu_ff      <= csr_data[15:0];
            CsrDestMac: dest_mac_ff <= csr_data;
            CsrSrcMac:  src_mac_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign req_tready = !q_full;
   assign in_accept  = req_tvalid && req_tready;

   ipdelin_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_accept  (in_accept),
      .rx_byte    (req_tdata),
      .chunk_end  (req_tlast),
      .mtu        (mtu_ff),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   ipdelin_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (q_empty),
      .full     (q_full)
   );

   ipdelin_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_cmd    (head_cmd),
      .empty       (q_empty),
      .pop         (pop),
      .dest_mac    (dest_mac_ff),
      .src_mac     (src_mac_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .frame_byte  (frame_byte),
      .frame_first (frame_first),
      .frame_last  (frame_last),
      .status      (status),
      .run_last    (run_last)
   );

   assign rsp_tdata = {7'd0, run_last, frame_byte};
   assign rsp_tuser = {status, frame_first};
   assign rsp_tlast = frame_last;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ip_stream_packet_delineator_core: directed and random byte
// streams are compared result by result with a behavioral delineator model kept here.
// Depends on ipdelin_pkg and the RTL of the delineator.
module tb;
   import ipdelin_pkg::*;

   localparam logic [15:0] MtuAtReset     = 16'd1500;
   localparam logic [47:0] DestMacAtReset = 48'h0;
   localparam logic [47:0] SrcMacAtReset  = 48'hB69124A81472;
   localparam logic [1:0]  CsrUnused      = 2'd3;
   localparam int          HoldOffCycles  = 300;
   localparam int          SettleCycles   = 32;
   localparam longint      TimeoutNs      = 64'd5_000_000;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HEADER,
      PH_BODY,
      PH_DISCARD
   } delin_phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       frame_first;
      logic       frame_last;
      status_type status;
      logic       run_last;
   } frame_result_type;

   // A directed row carries its expected result only when it is a single error.
   typedef struct packed {
      logic [7:0] data;
      logic       chunk_end;
      logic       known;
      status_type code;
   } directed_row_type;

   localparam directed_row_type DirectedRows [28] = '{
      // Bad version on a chunk end returns to hunting right away.
      '{8'hFF, 1'b1, 1'b1, ST_BAD_VERSION},
      // Bad version inside a chunk drops the rest of that chunk.
      '{8'h00, 1'b0, 1'b1, ST_BAD_VERSION},
      '{8'h45, 1'b0, 1'b0, ST_FRAME},
      '{8'h12, 1'b1, 1'b0, ST_FRAME},
      // Shortest IPv4 packet, with its header split by a chunk end.
      '{8'h45, 1'b0, 1'b0, ST_FRAME},
      '{8'h00, 1'b1, 1'b0, ST_FRAME},
      '{8'h00, 1'b0, 1'b0, ST_FRAME},
      '{8'h04, 1'b0, 1'b0, ST_FRAME},
      // IPv4 total length below the minimum.
      '{8'h4F, 1'b0, 1'b0, ST_FRAME},
      '{8'hFF, 1'b0, 1'b0, ST_FRAME},
      '{8'h00, 1'b0, 1'b0, ST_FRAME},
      '{8'h03, 1'b0, 1'b1, ST_BAD_LENGTH},
      '{8'hAA, 1'b1, 1'b0, ST_FRAME},
      // IPv6 payload length below the minimum, rejected on a chunk end.
      '{8'h6F, 1'b0, 1'b0, ST_FRAME},
      '{8'hFF, 1'b0, 1'b0, ST_FRAME},
      '{8'hFF, 1'b0, 1'b0, ST_FRAME},
      '{8'hFF, 1'b0, 1'b0, ST_FRAME},
      '{8'h00, 1'b0, 1'b0, ST_FRAME},
      '{8'h05, 1'b1, 1'b1, ST_BAD_LENGTH},
      // IPv4 packet with a single body byte.
      '{8'h40, 1'b0, 1'b0, ST_FRAME},
      '{8'h00, 1'b0, 1'b0, ST_FRAME},
      '{8'h00, 1'b0, 1'b0, ST_FRAME},
      '{8'h05, 1'b0, 1'b0, ST_FRAME},
      '{8'hFF, 1'b1, 1'b0, ST_FRAME},
      // One byte longer than the default mtu.
      '{8'h45, 1'b0, 1'b0, ST_FRAME},
      '{8'h00, 1'b0, 1'b0, ST_FRAME},
      '{8'h05, 1'b0, 1'b0, ST_FRAME},
      '{8'hDD, 1'b1, 1'b1, ST_BAD_LENGTH}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] rx_byte
   logic        req_tlast = 1'b0;    // chunk_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [7:0] frame_byte, [8] run_last
   logic [2:0]  rsp_tuser;           // [0] frame_first, [2:1] status
   logic        rsp_tlast;           // frame_last
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CsrMtu;
   logic [47:0] csr_data = 48'h0;

   ip_stream_packet_delineator_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   frame_result_type expected_frame_q [$];
   frame_result_type step_frames [$];
   int failures = 0;
   int items_sent = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;

   // Delineator model state and its copy of the registers.
   delin_phase_type dl_phase = PH_HUNT;
   logic [7:0]   dl_hdr [6];
   int           dl_hdr_cnt = 0;
   logic         dl_v6 = 1'b0;
   logic [15:0]  dl_left = 16'd0;
   logic [15:0]  dl_mtu = MtuAtReset;
   logic [47:0]  dl_dmac = DestMacAtReset;
   logic [47:0]  dl_smac = SrcMacAtReset;

   function automatic void push_frame_byte(input logic [7:0] d, input logic f,
                                           input logic l, input status_type s);
      step_frames.push_back('{data: d, frame_first: f, frame_last: l, status: s,
                              run_last: 1'b0});
   endfunction

   function automatic void enter_discard(input logic ce);
      dl_phase = ce ? PH_HUNT : PH_DISCARD;
      dl_hdr_cnt = 0;
      dl_left = 16'd0;
   endfunction

   // Works out the results that one accepted request causes, into step_frames.
   function automatic void delineate_byte(input logic [7:0] b, input logic ce);
      logic [3:0]  ver;
      logic [15:0] pl;
      logic [16:0] total;
      logic [15:0] eth;
      logic        ok;
      int          need;
      int          idx;
      int          i;
      step_frames.delete();
      case (dl_phase)
         PH_HUNT: begin
            ver = b[7:4];
            if (ver != VerIpv4 && ver != VerIpv6) begin
               push_frame_byte(8'h00, 1'b0, 1'b0, ST_BAD_VERSION);
               enter_discard(ce);
            end else begin
               dl_v6 = (ver == VerIpv6);
               dl_hdr[0] = b;
               dl_hdr_cnt = 1;
               dl_phase = PH_HEADER;
            end
         end
         PH_HEADER: begin
            need = dl_v6 ? 6 : 4;
            idx = (dl_hdr_cnt >= need) ? need - 1 : dl_hdr_cnt;
            dl_hdr[idx] = b;
            dl_hdr_cnt = idx + 1;
            if (dl_hdr_cnt == need) begin
               if (dl_v6) begin
                  pl = {dl_hdr[4], dl_hdr[5]};
                  total = 17'd40 + {1'b0, pl};
                  ok = (pl >= 16'd6) && (total <= {1'b0, dl_mtu});
               end else begin
                  total = {1'b0, dl_hdr[2], dl_hdr[3]};
                  ok = (total >= 17'd4) && (total <= {1'b0, dl_mtu});
               end
               if (!ok) begin
                  push_frame_byte(8'h00, 1'b0, 1'b0, ST_BAD_LENGTH);
                  enter_discard(ce);
               end else begin
                  for (i = 0; i < 6; i++)
                     push_frame_byte(dl_dmac[47 - 8 * i -: 8], i == 0, 1'b0, ST_FRAME);
                  for (i = 0; i < 6; i++)
                     push_frame_byte(dl_smac[47 - 8 * i -: 8], 1'b0, 1'b0, ST_FRAME);
                  eth = dl_v6 ? 16'h86DD : 16'h0800;
                  push_frame_byte(eth[15:8], 1'b0, 1'b0, ST_FRAME);
                  push_frame_byte(eth[7:0], 1'b0, 1'b0, ST_FRAME);
                  dl_left = 16'(total - 17'(need));
                  for (i = 0; i < need; i++)
                     push_frame_byte(dl_hdr[i], 1'b0, (i == need - 1) && (dl_left == 0),
                                     ST_FRAME);
                  dl_hdr_cnt = 0;
                  dl_phase = (dl_left != 0) ? PH_BODY : PH_HUNT;
               end
            end
         end
         PH_BODY: begin
            if (dl_left != 0) dl_left = dl_left - 16'd1;
            push_frame_byte(b, 1'b0, dl_left == 0, ST_FRAME);
            if (dl_left == 0) dl_phase = PH_HUNT;
         end
         default: begin
            if (ce) dl_phase = PH_HUNT;
         end
      endcase
      if (step_frames.size() != 0) step_frames[step_frames.size() - 1].run_last = 1'b1;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         failures++;
      end
   endfunction

   // Receiver: checks every accepted result and throttles rsp_tready.
   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_frame_q.size() == 0) begin
            $error("result with no request pending: tdata %0h tuser %0h", rsp_tdata, rsp_tuser);
            failures++;
         end else begin
            want = expected_frame_q.pop_front();
            check_field("frame_byte", want.data, rsp_tdata[7:0]);
            check_field("frame_first", {7'd0, want.frame_first}, {7'd0, rsp_tuser[0]});
            check_field("frame_last", {7'd0, want.frame_last}, {7'd0, rsp_tlast});
            check_field("status", {6'd0, want.status}, {6'd0, rsp_tuser[2:1]});
            check_field("run_last", {7'd0, want.run_last}, {7'd0, rsp_tdata[8]});
         end
      end
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HoldOffCycles;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_req(input logic [7:0] b, input logic ce, input logic known = 1'b0,
                           input status_type code = ST_FRAME);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= ce;
      do @(posedge clock); while (!req_tready);
      delineate_byte(b, ce);
      if (known)
         expected_frame_q.push_back('{data: 8'h00, frame_first: 1'b0, frame_last: 1'b0,
                                      status: code, run_last: 1'b1});
      else
         foreach (step_frames[i]) expected_frame_q.push_back(step_frames[i]);
      items_sent++;
   endtask

   task automatic wait_for_frames_done();
      req_tvalid <= 1'b0;
      while (expected_frame_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [47:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         CsrMtu:     dl_mtu = value[15:0];
         CsrDestMac: dl_dmac = value;
         CsrSrcMac:  dl_smac = value;
         default:    ;
      endcase
   endtask

   // Mostly well-formed packets with random content; the rest are bad lengths and noise.
   // Well-formed packets are sized to fit in the bytes that the phase still has to send.
   task automatic send_random_packet(input int budget);
      logic [7:0]  seq [$];
      logic [15:0] lo;
      logic [15:0] hi;
      logic [15:0] len;
      logic        v6;
      logic        good;
      int          kind;
      int          body;
      int          i;
      kind = $urandom_range(99);
      v6 = ($urandom_range(99) < ((budget >= 46) ? 60 : 30));
      good = (kind < 70);
      if (good && budget < 46) v6 = 1'b0;
      if (kind >= 85) begin
         for (i = $urandom_range(8, 1); i > 0; i--)
            send_req(8'($urandom_range(255)), $urandom_range(3) == 0);
         return;
      end
      if (good) begin
         if (v6) begin
            lo = 16'd6;
            hi = (dl_mtu >= 16'd46) ? dl_mtu - 16'd40 : 16'd6;
            if (hi > lo + 16'd8) hi = lo + 16'd8;
            if (hi > 16'(budget - 40)) hi = 16'(budget - 40);
         end else begin
            lo = 16'd4;
            hi = (dl_mtu >= 16'd4) ? dl_mtu : 16'd4;
            if (hi > lo + 16'd24) hi = lo + 16'd24;
            if (hi > 16'(budget)) hi = (budget > 4) ? 16'(budget) : 16'd4;
         end
         len = ($urandom_range(3) == 0) ? hi : 16'($urandom_range(hi, lo));
         body = v6 ? int'(len) + 34 : int'(len) - 4;
      end else begin
         if ($urandom_range(1) == 0)
            len = 16'($urandom_range(v6 ? 5 : 3, 0));
         else if (v6)
            len = (dl_mtu < 16'd40) ? 16'($urandom) : dl_mtu - 16'd39 + 16'($urandom_range(3));
         else
            len = (dl_mtu == 16'hFFFF) ? 16'($urandom_range(3)) : dl_mtu + 16'd1;
         body = $urandom_range(4);
      end
      seq.push_back({v6 ? VerIpv6 : VerIpv4, 4'($urandom_range(15))});
      seq.push_back(8'($urandom_range(255)));
      if (v6) begin
         seq.push_back(8'($urandom_range(255)));
         seq.push_back(8'($urandom_range(255)));
      end
      seq.push_back(len[15:8]);
      seq.push_back(len[7:0]);
      for (i = 0; i < body; i++) seq.push_back(8'($urandom_range(255)));
      foreach (seq[i]) begin
         if (i == seq.size() - 1)
            send_req(seq[i], good ? ($urandom_range(1) == 1) : 1'b1);
         else
            send_req(seq[i], $urandom_range(99) < 12);
      end
   endtask

   task automatic run_phase(input logic [15:0] mtu, input logic [47:0] dmac,
                            input logic [47:0] smac, input int idle_pct,
                            input int stall_pct, input int n_items, input logic hold_off);
      int target;
      wait_for_frames_done();
      csr_write(CsrMtu, {32'd0, mtu});
      csr_write(CsrDestMac, dmac);
      csr_write(CsrSrcMac, smac);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      // The receiver holds off while requests keep coming, so the queue backs up.
      if (hold_off) hold_requests++;
      target = items_sent + n_items;
      while (items_sent < target) send_random_packet(target - items_sent);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      recv_stall_pct = 20;
      foreach (DirectedRows[i])
         send_req(DirectedRows[i].data, DirectedRows[i].chunk_end, DirectedRows[i].known,
                  DirectedRows[i].code);
      wait_for_frames_done();
      csr_write(CsrUnused, 48'($urandom));
      run_phase(16'hFFFF, 48'hFFFF_FFFF_FFFF, 48'h0, 0, 0, 46, 1'b1);
      run_phase(16'($urandom_range(80, 46)), 48'({$urandom, $urandom}),
                48'({$urandom, $urandom}), 67, 0, 8, 1'b0);
      run_phase(16'd40, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                0, 67, 8, 1'b0);
      run_phase(16'd0, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                30, 30, 4, 1'b0);
      run_phase(MtuAtReset, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                30, 30, 8, 1'b0);
      wait_for_frames_done();
      if (failures == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #(TimeoutNs);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
